// ===== design/brmu_pkg.sv =====
package brmu_pkg;

  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned NUM_SLOTS = 6;
  localparam int unsigned NUM_HIGH  = 5;
  localparam int unsigned HIGH_BASE = 8;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  mode_t;
  typedef logic [2:0]  slot_t;
  typedef logic [3:0]  code_t;

  localparam code_t OP_RDREG   = 4'd0;
  localparam code_t OP_WRREG   = 4'd1;
  localparam code_t OP_RDSTAT  = 4'd2;
  localparam code_t OP_WRSTAT  = 4'd3;
  localparam code_t OP_RDSAVED = 4'd4;
  localparam code_t OP_WRSAVED = 4'd5;
  localparam code_t OP_EXCEPT  = 4'd6;
  localparam code_t OP_ERET    = 4'd7;
  localparam code_t OP_COND    = 4'd8;

  localparam code_t REG_SP = 4'd13;
  localparam code_t REG_LR = 4'd14;
  localparam code_t REG_PC = 4'd15;

  localparam mode_t MODE_USER = 5'h10;
  localparam mode_t MODE_FIQ  = 5'h11;
  localparam mode_t MODE_IRQ  = 5'h12;
  localparam mode_t MODE_SVC  = 5'h13;
  localparam mode_t MODE_ABT  = 5'h17;
  localparam mode_t MODE_UND  = 5'h1B;
  localparam mode_t MODE_SYS  = 5'h1F;

  localparam slot_t SLOT_USER = 3'd0;
  localparam slot_t SLOT_FIQ  = 3'd1;
  localparam slot_t SLOT_IRQ  = 3'd2;
  localparam slot_t SLOT_SVC  = 3'd3;
  localparam slot_t SLOT_ABT  = 3'd4;
  localparam slot_t SLOT_UND  = 3'd5;

  localparam word_t IRQ_MASK  = 32'h0000_0080;
  localparam word_t FIQ_MASK  = 32'h0000_0040;
  localparam word_t MODE_BIT4 = 32'h0000_0010;
  localparam word_t CTRL_BYTE = 32'h0000_00FF;
  localparam word_t FLAG_BITS = 32'hFFFF_FF00;
  localparam word_t STATUS_RESET = 32'h0000_00D3;
  localparam word_t ADDR_STEP = 32'd4;

  localparam code_t COND_EQ = 4'h0;
  localparam code_t COND_NE = 4'h1;
  localparam code_t COND_CS = 4'h2;
  localparam code_t COND_CC = 4'h3;
  localparam code_t COND_MI = 4'h4;
  localparam code_t COND_PL = 4'h5;
  localparam code_t COND_VS = 4'h6;
  localparam code_t COND_VC = 4'h7;
  localparam code_t COND_HI = 4'h8;
  localparam code_t COND_LS = 4'h9;
  localparam code_t COND_GE = 4'hA;
  localparam code_t COND_LT = 4'hB;
  localparam code_t COND_GT = 4'hC;
  localparam code_t COND_LE = 4'hD;
  localparam code_t COND_AL = 4'hE;

  typedef struct packed {
    code_t op;
    code_t reg_index;
    word_t data_value;
    word_t vector_addr;
    mode_t new_mode;
    code_t cond_code;
  } item_t;

  typedef struct packed {
    word_t read_data;
    logic  cond_pass;
    mode_t mode_now;
  } result_t;

  function automatic slot_t slot_of(input mode_t m);
    case (m)
      MODE_FIQ: slot_of = SLOT_FIQ;
      MODE_IRQ: slot_of = SLOT_IRQ;
      MODE_SVC: slot_of = SLOT_SVC;
      MODE_ABT: slot_of = SLOT_ABT;
      MODE_UND: slot_of = SLOT_UND;
      default:  slot_of = SLOT_USER;
    endcase
  endfunction

  function automatic logic cond_ok(input word_t st, input code_t c);
    logic n, z, cy, v;
    n  = st[31];
    z  = st[30];
    cy = st[29];
    v  = st[28];
    case (c)
      COND_EQ: cond_ok = z;
      COND_NE: cond_ok = !z;
      COND_CS: cond_ok = cy;
      COND_CC: cond_ok = !cy;
      COND_MI: cond_ok = n;
      COND_PL: cond_ok = !n;
      COND_VS: cond_ok = v;
      COND_VC: cond_ok = !v;
      COND_HI: cond_ok = cy && !z;
      COND_LS: cond_ok = !cy || z;
      COND_GE: cond_ok = (n == v);
      COND_LT: cond_ok = (n != v);
      COND_GT: cond_ok = !z && (n == v);
      COND_LE: cond_ok = z || (n != v);
      COND_AL: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  endfunction

endpackage

// ===== design/brmu_exec.sv =====
module brmu_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  brmu_pkg::item_t  item,
  output brmu_pkg::result_t res
);

  brmu_pkg::word_t regs_r [brmu_pkg::NUM_REGS];
  brmu_pkg::word_t regs_nxt [brmu_pkg::NUM_REGS];
  brmu_pkg::word_t stk_r [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t stk_nxt [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t lnk_r [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t lnk_nxt [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t ssb_r [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t ssb_nxt [brmu_pkg::NUM_SLOTS];
  brmu_pkg::word_t fast_r [brmu_pkg::NUM_HIGH];
  brmu_pkg::word_t fast_nxt [brmu_pkg::NUM_HIGH];
  brmu_pkg::word_t user_r [brmu_pkg::NUM_HIGH];
  brmu_pkg::word_t user_nxt [brmu_pkg::NUM_HIGH];
  brmu_pkg::word_t status_r, status_nxt;
  brmu_pkg::mode_t mode_r, mode_nxt;

  brmu_pkg::slot_t cur_slot, tgt_slot;
  brmu_pkg::word_t saved_cur, wr_word, rd_data;
  brmu_pkg::mode_t sw_mode;
  logic            sw_en, sw_take, pass;

  assign cur_slot  = brmu_pkg::slot_of(mode_r);
  assign saved_cur = ssb_r[cur_slot];
  assign wr_word   = item.data_value | brmu_pkg::MODE_BIT4;

  always_comb begin
    sw_en   = 1'b0;
    sw_mode = mode_r;
    case (item.op)
      brmu_pkg::OP_WRSTAT: begin
        if (mode_r != brmu_pkg::MODE_USER) begin
          sw_en   = 1'b1;
          sw_mode = wr_word[4:0];
        end
      end
      brmu_pkg::OP_EXCEPT: begin
        sw_en   = 1'b1;
        sw_mode = item.new_mode;
      end
      brmu_pkg::OP_ERET: begin
        if (cur_slot != brmu_pkg::SLOT_USER) begin
          sw_en   = 1'b1;
          sw_mode = saved_cur[4:0];
        end
      end
      default: begin
        sw_en = 1'b0;
      end
    endcase
  end

  assign sw_take  = sw_en && (sw_mode != mode_r);
  assign tgt_slot = brmu_pkg::slot_of(sw_mode);

  always_comb begin
    regs_nxt   = regs_r;
    stk_nxt    = stk_r;
    lnk_nxt    = lnk_r;
    ssb_nxt    = ssb_r;
    fast_nxt   = fast_r;
    user_nxt   = user_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    rd_data    = '0;
    pass       = 1'b0;

    // bank out the old mode, then bank in the new one
    if (sw_take) begin
      stk_nxt[cur_slot] = regs_r[brmu_pkg::REG_SP];
      lnk_nxt[cur_slot] = regs_r[brmu_pkg::REG_LR];
      for (int i = 0; i < brmu_pkg::NUM_HIGH; i++) begin
        if (mode_r == brmu_pkg::MODE_FIQ) begin
          fast_nxt[i] = regs_r[4'(brmu_pkg::HIGH_BASE + i)];
        end else begin
          user_nxt[i] = regs_r[4'(brmu_pkg::HIGH_BASE + i)];
        end
      end
      regs_nxt[brmu_pkg::REG_SP] = stk_nxt[tgt_slot];
      regs_nxt[brmu_pkg::REG_LR] = lnk_nxt[tgt_slot];
      for (int i = 0; i < brmu_pkg::NUM_HIGH; i++) begin
        regs_nxt[4'(brmu_pkg::HIGH_BASE + i)] =
          (sw_mode == brmu_pkg::MODE_FIQ) ? fast_nxt[i] : user_nxt[i];
      end
      mode_nxt   = sw_mode;
      status_nxt = {status_r[31:5], sw_mode};
    end

    case (item.op)
      brmu_pkg::OP_RDREG: begin
        rd_data = regs_r[item.reg_index];
      end
      brmu_pkg::OP_WRREG: begin
        regs_nxt[item.reg_index] = item.data_value;
      end
      brmu_pkg::OP_RDSTAT: begin
        rd_data = status_r;
      end
      brmu_pkg::OP_WRSTAT: begin
        if (mode_r == brmu_pkg::MODE_USER) begin
          status_nxt = (status_r & brmu_pkg::CTRL_BYTE) |
                       (item.data_value & brmu_pkg::FLAG_BITS);
        end else begin
          status_nxt = wr_word;
        end
      end
      brmu_pkg::OP_RDSAVED: begin
        rd_data = (cur_slot != brmu_pkg::SLOT_USER) ? saved_cur : status_r;
      end
      brmu_pkg::OP_WRSAVED: begin
        if (cur_slot != brmu_pkg::SLOT_USER) begin
          ssb_nxt[cur_slot] = item.data_value;
        end
      end
      brmu_pkg::OP_EXCEPT: begin
        if (tgt_slot != brmu_pkg::SLOT_USER) begin
          ssb_nxt[tgt_slot] = status_r;
        end
        status_nxt = status_nxt | brmu_pkg::IRQ_MASK |
                     ((item.new_mode == brmu_pkg::MODE_FIQ) ? brmu_pkg::FIQ_MASK : '0);
        regs_nxt[brmu_pkg::REG_LR] = item.data_value + brmu_pkg::ADDR_STEP;
        regs_nxt[brmu_pkg::REG_PC] = item.vector_addr - brmu_pkg::ADDR_STEP;
      end
      brmu_pkg::OP_ERET: begin
        if (cur_slot != brmu_pkg::SLOT_USER) begin
          status_nxt = saved_cur;
        end
      end
      brmu_pkg::OP_COND: begin
        pass = brmu_pkg::cond_ok(status_r, item.cond_code);
      end
      default: begin
        rd_data = '0;
      end
    endcase
  end

  assign res.read_data = rd_data;
  assign res.cond_pass = pass;
  assign res.mode_now  = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < brmu_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      for (int i = 0; i < brmu_pkg::NUM_SLOTS; i++) begin
        stk_r[i] <= '0;
        lnk_r[i] <= '0;
        ssb_r[i] <= '0;
      end
      for (int i = 0; i < brmu_pkg::NUM_HIGH; i++) begin
        fast_r[i] <= '0;
        user_r[i] <= '0;
      end
      status_r <= brmu_pkg::STATUS_RESET;
      mode_r   <= brmu_pkg::MODE_SVC;
    end else if (en) begin
      regs_r   <= regs_nxt;
      stk_r    <= stk_nxt;
      lnk_r    <= lnk_nxt;
      ssb_r    <= ssb_nxt;
      fast_r   <= fast_nxt;
      user_r   <= user_nxt;
      status_r <= status_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

// ===== design/banked_register_mode_unit.sv =====
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall   | op, reg_index, data_value, vector_addr,
//         |           |                       | new_mode, cond_code
// out_    | output    | out_valid / out_stall | read_data, cond_pass, mode_now
//
// One beat per cycle sustained while out_stall is low; a result passes through the input
// register, then the result register behind the combinational register/bank logic.
// All register and bank state lives in flops and updates as the item moves to the result
// register, so the next beat sees it at once.
// Synchronous active-low reset restores supervisor mode, status 0xD3 and zeroed registers.
// out_stall holds the result register; in_stall rises only when the input register is
// full and cannot advance.
module banked_register_mode_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_data_value,
  input  logic [31:0] in_vector_addr,
  input  logic [4:0]  in_new_mode,
  input  logic [3:0]  in_cond_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_cond_pass,
  output logic [4:0]  out_mode_now
);

  brmu_pkg::item_t   item_r;
  brmu_pkg::result_t res;
  brmu_pkg::result_t res_r;
  logic              item_vld_r, item_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              adv, in_take;

  assign adv     = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !adv;
  assign in_take = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_take) begin
      item_vld_nxt = 1'b1;
    end else if (adv) begin
      item_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op          <= in_op;
      item_r.reg_index   <= in_reg_index;
      item_r.data_value  <= in_data_value;
      item_r.vector_addr <= in_vector_addr;
      item_r.new_mode    <= in_new_mode;
      item_r.cond_code   <= in_cond_code;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  brmu_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid     = out_vld_r;
  assign out_read_data = res_r.read_data;
  assign out_cond_pass = res_r.cond_pass;
  assign out_mode_now  = res_r.mode_now;

endmodule
